@@ hw/rtl/ehg_pkg.sv @@
`timescale 1ns / 1ps

package ehg_pkg;

    // Event codes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_VELOCITY   = 3'd1;
    localparam logic [2:0] OP_MODE_REQ   = 3'd2;
    localparam logic [2:0] OP_EMERG_REQ  = 3'd3;
    localparam logic [2:0] OP_STATE_RPT  = 3'd4;
    localparam logic [2:0] OP_EMERG_RPT  = 3'd5;
    localparam logic [2:0] OP_BOOT_READY = 3'd6;

    // Send kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_VELOCITY = 2'd1;
    localparam logic [1:0] KIND_MODE     = 2'd2;
    localparam logic [1:0] KIND_EMERG    = 2'd3;

    // Controller modes
    localparam logic [1:0] MODE_STOP    = 2'd0;
    localparam logic [1:0] MODE_AUTO    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT    = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] FAST_INTERVAL_RST = 16'd200;
    localparam logic [15:0] SLOW_INTERVAL_RST = 16'd1000;
    localparam logic [7:0]  FAST_LIMIT_RST    = 8'd3;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               is_dock_report;
        logic [3:0]         value;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic               link_up;
    } t_evt;

    typedef struct packed {
        logic [1:0]         send_kind;
        logic [1:0]         send_mode;
        logic signed [31:0] send_linear;
        logic signed [31:0] send_angular;
        logic               rejected;
        logic [1:0]         mode_now;
        logic               docked_now;
        logic               emergency_confirmed;
        logic               emergency_pending;
        logic [15:0]        resend_count;
    } t_res;

endpackage

@@ hw/rtl/ehg_evt_if.sv @@
`timescale 1ns / 1ps

interface ehg_evt_if;
    import ehg_pkg::*;

    logic valid;
    logic ready;
    t_evt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/ehg_res_if.sv @@
`timescale 1ns / 1ps

interface ehg_res_if;
    import ehg_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/emergency_handshake_gate.sv @@
`timescale 1ns / 1ps

// Command gate and emergency handshake for a motion controller link.
// Channels:
//   i_evt  - event requests: tick, velocity, mode request, emergency request,
//            controller state / emergency / boot / dock reports.
//   o_res  - one result request per event: what to send to the controller,
//            a reject flag and the tracked state after the event.
//   i_cfg_* - write port for the resend timing registers (fast interval,
//            slow interval, fast retry limit); write only while idle.
// Result: the result of an event appears on o_res in the cycle after the
//   event is taken. Throughput: one event per cycle unless o_res stalls, set
//   by the single update stage that writes the state and the result register together.
// Stall: i_evt.ready follows room in the result register; while o_res is
//   held (valid without ready) the result holds and no new event is taken,
//   and the event is taken in the same cycle the held result drains.
// Reset: mode unknown, not docked, no emergency, counters zero, timing
//   registers 200 / 1000 / 3, result register empty.
module emergency_handshake_gate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ehg_evt_if.sink                        i_evt,
    ehg_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [ehg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ehg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ehg_pkg::*;

    // Timing registers
    logic [15:0] r_fast_interval;
    logic [15:0] r_slow_interval;
    logic [7:0]  r_fast_limit;

    // Tracked state
    logic [1:0]  r_mode, n_mode;
    logic        r_docked, n_docked;
    logic        r_confirmed, n_confirmed;
    logic        r_pending, n_pending;
    logic [15:0] r_resend, n_resend;
    logic [15:0] r_elapsed, n_elapsed;

    // Result register
    logic        r_out_valid;
    t_res        r_out, n_out;

    logic        accept;
    t_evt        evt;
    logic        emerg;
    logic [15:0] elapsed_inc;
    logic [15:0] interval;

    // Take an event whenever the result register is empty or draining.
    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign accept      = i_evt.valid && i_evt.ready;
    assign evt         = i_evt.data;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign emerg       = r_confirmed || r_pending;
    assign elapsed_inc = (r_elapsed == SAT16) ? r_elapsed : r_elapsed + 16'd1;
    // Fast interval for the first resends, slow after that.
    assign interval    = (r_resend < {8'd0, r_fast_limit}) ? r_fast_interval
                                                            : r_slow_interval;

    always_comb begin
        n_mode      = r_mode;
        n_docked    = r_docked;
        n_confirmed = r_confirmed;
        n_pending   = r_pending;
        n_resend    = r_resend;
        n_elapsed   = r_elapsed;

        n_out              = '0;
        n_out.send_kind    = KIND_NONE;
        n_out.send_mode    = MODE_STOP;

        if (evt.is_dock_report) begin
            // Dock report overrides whatever the opcode says.
            n_docked = (evt.value == 4'd1);
        end else begin
            unique case (evt.opcode)
                OP_TICK: begin
                    if (r_pending) begin
                        n_elapsed = elapsed_inc;
                        if (!r_confirmed && evt.link_up && elapsed_inc >= interval) begin
                            n_out.send_kind = KIND_EMERG;
                            n_resend  = (r_resend == SAT16) ? r_resend : r_resend + 16'd1;
                            n_elapsed = '0;
                        end
                    end
                end
                OP_VELOCITY: begin
                    if (evt.link_up && !emerg && r_mode == MODE_AUTO) begin
                        n_out.send_kind    = KIND_VELOCITY;
                        n_out.send_linear  = evt.linear_speed;
                        n_out.send_angular = evt.angular_speed;
                    end else begin
                        n_out.rejected = 1'b1;
                    end
                end
                OP_MODE_REQ: begin
                    // Out-of-range modes are refused; during an emergency only stop passes.
                    if (!evt.link_up || evt.value > 4'd2 || (emerg && evt.value != 4'd0)) begin
                        n_out.rejected = 1'b1;
                    end else begin
                        n_out.send_kind = KIND_MODE;
                        n_out.send_mode = evt.value[1:0];
                    end
                end
                OP_EMERG_REQ: begin
                    if (evt.value != 4'd0) begin
                        if (!evt.link_up || emerg) begin
                            n_out.rejected = 1'b1;
                        end else begin
                            n_pending       = 1'b1;
                            n_resend        = '0;
                            n_elapsed       = '0;
                            n_out.send_kind = KIND_EMERG;
                        end
                    end
                end
                OP_STATE_RPT: begin
                    if (evt.value <= 4'd2) begin
                        n_mode = evt.value[1:0];
                    end
                end
                OP_EMERG_RPT: begin
                    // Acknowledge or clear; any other code is ignored.
                    if (evt.value == 4'd1 || evt.value == 4'd0) begin
                        n_confirmed = (evt.value == 4'd1);
                        n_pending   = 1'b0;
                        n_resend    = '0;
                        n_elapsed   = '0;
                    end
                end
                OP_BOOT_READY: begin
                    n_mode      = MODE_STOP;
                    n_docked    = 1'b0;
                    n_confirmed = 1'b0;
                    n_pending   = 1'b0;
                    n_resend    = '0;
                    n_elapsed   = '0;
                end
                default: begin
                end
            endcase
        end

        n_out.mode_now            = n_mode;
        n_out.docked_now          = n_docked;
        n_out.emergency_confirmed = n_confirmed;
        n_out.emergency_pending   = n_pending;
        n_out.resend_count        = n_resend;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_interval <= FAST_INTERVAL_RST;
            r_slow_interval <= SLOW_INTERVAL_RST;
            r_fast_limit    <= FAST_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAST_INTERVAL: r_fast_interval <= i_cfg_wdata;
                CFG_SLOW_INTERVAL: r_slow_interval <= i_cfg_wdata;
                CFG_FAST_LIMIT:    r_fast_limit    <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // State advances only on a taken event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_UNKNOWN;
            r_docked    <= 1'b0;
            r_confirmed <= 1'b0;
            r_pending   <= 1'b0;
            r_resend    <= '0;
            r_elapsed   <= '0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_docked    <= n_docked;
            r_confirmed <= n_confirmed;
            r_pending   <= n_pending;
            r_resend    <= n_resend;
            r_elapsed   <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // Confirmed and pending never hold together.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_confirmed && r_pending))
        else $error("emergency confirmed and pending at once");

    // Retry counters only run while a request is pending.
    a_counters_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_resend != 16'd0 || r_elapsed != 16'd0) |-> r_pending)
        else $error("resend counters nonzero without pending request");

    // A taken event always leaves a result behind.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("event taken without a result");

    // A command that is sent is never flagged as rejected.
    a_sent_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_kind != KIND_NONE) |-> !r_out.rejected)
        else $error("sent command marked rejected");

endmodule
